/* rtl/ccs_pkg.sv */
// ----------------------------------------------------------------------------
// ccs_pkg: shared types, codes and scan step of the comment stripper
// Holds the scan mode codes, the byte constants and the one-word step
// function that turns one input word into up to two kept bytes.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ModeW  = 3;
  // Result queue depth; one input word may push two entries.
  localparam int unsigned QDepth = 4;

  localparam logic [ByteW-1:0] ChSlash   = 8'h2F;
  localparam logic [ByteW-1:0] ChStar    = 8'h2A;
  localparam logic [ByteW-1:0] ChLf      = 8'd10;
  localparam logic [ByteW-1:0] ChCr      = 8'd13;
  localparam logic [ByteW-1:0] LineEndRst = 8'd13;

  // Scan mode codes.
  localparam logic [ModeW-1:0] ModeNormal = 3'd0;
  localparam logic [ModeW-1:0] ModeHeld   = 3'd1;
  localparam logic [ModeW-1:0] ModeLine   = 3'd2;
  localparam logic [ModeW-1:0] ModeBlock  = 3'd3;
  localparam logic [ModeW-1:0] ModeStar   = 3'd4;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [1:0]       num;
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
  } step_t;

  typedef struct packed {
    logic [ByteW-1:0] kept;
    logic             last;
  } entry_t;

  function automatic step_t scan_step(input logic [ModeW-1:0] mode,
                                      input logic [ByteW-1:0] b,
                                      input logic             fin,
                                      input logic [ByteW-1:0] line_end);
    step_t r;
    logic  eol;
    r       = '0;
    r.mode  = mode;
    r.byte0 = b;
    r.byte1 = b;
    eol     = (b == ChLf) || (b == ChCr);
    unique case (mode)
      ModeHeld: begin
        if (b == ChSlash) begin
          r.mode = ModeLine;
        end else if (b == ChStar) begin
          r.mode = ModeBlock;
        end else begin
          r.byte0 = ChSlash;
          r.num   = 2'd2;
          r.mode  = ModeNormal;
        end
      end
      ModeLine: begin
        if (b == line_end) begin
          r.num  = 2'd1;
          r.mode = ModeNormal;
        end
      end
      ModeBlock: begin
        if (b == ChStar) begin
          r.mode = ModeStar;
        end else if (eol) begin
          r.num = 2'd1;
        end
      end
      ModeStar: begin
        if (b == ChSlash) begin
          r.mode = ModeNormal;
        end else if (b != ChStar) begin
          if (eol) begin
            r.num = 2'd1;
          end
          r.mode = ModeBlock;
        end
      end
      default: begin
        if (b == ChSlash) begin
          r.mode = ModeHeld;
        end else begin
          r.num  = 2'd1;
          r.mode = ModeNormal;
        end
      end
    endcase
    // Flush a held slash at end of text, then drop back to normal.
    if (fin) begin
      if (r.mode == ModeHeld) begin
        if (r.num == 2'd0) begin
          r.byte0 = ChSlash;
        end else begin
          r.byte1 = ChSlash;
        end
        r.num = r.num + 2'd1;
      end
      r.mode = ModeNormal;
    end
    return r;
  endfunction

endpackage

/* rtl/c_comment_stripper_unit.sv */
// ----------------------------------------------------------------------------
// c_comment_stripper_unit: C comment remover for a byte stream
// Registered input word, combinational scan step, small result queue.
// ----------------------------------------------------------------------------
// Usage: feed source text one byte per word on the input channel, with
// final_byte_i set on the last byte of a text; the block returns the text
// with line and block comments removed. After a double slash, bytes are
// dropped up to and excluding the configured line-end code (register written
// through cfg_we_i / cfg_wdata_i, reset value 13), which is passed. Inside a
// block comment only LF and CR are passed. A lone slash is held until the
// next byte shows it is plain text, then both are sent; a held slash is
// flushed on the final byte, and any open comment ends with the text.
// Throughput is one input word per cycle while the input is not stalled.
// A word is held in the input register until it is processed; its results
// are then written to the result queue, which drives the output. The
// output sends at most one byte per cycle, and a lone slash sent with its
// following byte makes two entries from one word; a four-entry result queue
// absorbs that and decouples the two sides, and the input stalls only when
// the queue cannot take two more entries. run_last_o marks the last byte
// produced by one input word.
// ----------------------------------------------------------------------------
module c_comment_stripper_unit #(
  parameter int unsigned QDepth = ccs_pkg::QDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [ccs_pkg::ByteW-1:0] cfg_wdata_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ccs_pkg::ByteW-1:0] text_byte_i,
  input  logic                     final_byte_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ccs_pkg::ByteW-1:0] kept_byte_o,
  output logic                     run_last_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  // Line-end code register.
  logic [ccs_pkg::ByteW-1:0] line_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_end_q <= ccs_pkg::LineEndRst;
    end else if (cfg_we_i) begin
      line_end_q <= cfg_wdata_i;
    end
  end

  // Input register.
  logic                      in_vld_q, in_vld_d;
  logic [ccs_pkg::ByteW-1:0] in_byte_q;
  logic                      in_fin_q;
  logic                      in_take;
  logic                      room;
  logic                      proc;

  // Scan state.
  logic [ccs_pkg::ModeW-1:0] mode_q, mode_d;
  ccs_pkg::step_t            step;

  // Result queue.
  ccs_pkg::entry_t           q_mem [QDepth];
  logic [PtrW-1:0]           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      pop;
  ccs_pkg::entry_t           ent0, ent1;

  // Room for the worst case of two entries from one word.
  assign room       = (cnt_q <= CntW'(QDepth - 2));
  assign proc       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Payload: hold while stalled, load on accept.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= text_byte_i;
      in_fin_q  <= final_byte_i;
    end
  end

  // One scan step per processed word.
  always_comb begin
    step   = ccs_pkg::scan_step(mode_q, in_byte_q, in_fin_q, line_end_q);
    mode_d = proc ? step.mode : mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ccs_pkg::ModeNormal;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Build queue entries; the last byte of the word carries the run flag.
  always_comb begin
    ent0.kept = step.byte0;
    ent0.last = (step.num == 2'd1);
    ent1.kept = step.byte1;
    ent1.last = 1'b1;
  end

  assign pop = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (proc) begin
      wr_ptr_d = wr_ptr_q + PtrW'(step.num);
      cnt_d    = cnt_d + CntW'(step.num);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
      cnt_d    = cnt_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && (step.num != 2'd0)) begin
      q_mem[wr_ptr_q] <= ent0;
    end
    if (proc && (step.num == 2'd2)) begin
      q_mem[wr_ptr_q + PtrW'(1)] <= ent1;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign kept_byte_o = q_mem[rd_ptr_q].kept;
  assign run_last_o  = q_mem[rd_ptr_q].last;

  // Queue never overfills.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("result queue count out of range");

  // Stall only when a word is waiting without room.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && (cnt_q > CntW'(QDepth - 2))))
    else $error("input stalled without cause");

  // End of text always returns the scanner to normal mode.
  a_final_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_fin_q) |=> (mode_q == ccs_pkg::ModeNormal))
    else $error("scan mode not cleared after final byte");

  // When no word is processed and nothing is popped, the queue count stays
  // unchanged.
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!proc && !pop) |=> $stable(cnt_q))
    else $error("queue count changed without push or pop");

endmodule
